### rtl/sit_pkg.sv
`default_nettype none
package sit_pkg;
	localparam int MaxEntriesDefault = 64;
	localparam logic [63:0] MixGolden = 64'h9e3779b97f4a7c15;
	localparam logic [63:0] IdSeed = 64'h00000000C0D1C0D1;
	localparam logic [6:0] CapReset = 7'd64;

	typedef enum logic [2:0] {
		K_REG = 3'd0, K_LKID = 3'd1, K_LKKEY = 3'd2, K_SDUE = 3'd3,
		K_SPROV = 3'd4, K_MPROV = 3'd5, K_CLR = 3'd6, K_NONE = 3'd7
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0, ST_FULL = 2'd1, ST_DUP = 2'd2, ST_NF = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE, S_H1, S_H2, S_H3, S_SRD, S_SCHK, S_MRD, S_MWR, S_INS, S_UPD,
		S_ERD, S_EOUT, S_OUT
	} state_t;

	typedef struct packed {
		logic [63:0] id;
		logic [63:0] k0;
		logic [63:0] k1;
		logic [63:0] k2;
		logic [31:0] cnt;
		logic [63:0] rf;
		logic [63:0] due;
		logic [63:0] prov;
	} entry_t;

	typedef struct packed {
		logic [1:0] status;
		logic [63:0] entry_id_out;
		logic [5:0] slot;
		logic [31:0] count_out;
		logic [63:0] ref_out;
		logic [63:0] due_out;
		logic [63:0] prov_out;
	} result_t;

	function automatic logic [63:0] mix(input logic [63:0] h, input logic [63:0] v);
		return h ^ (v + MixGolden + (h << 6) + (h >> 2));
	endfunction
endpackage
`default_nettype wire

### rtl/sit_if.sv
`default_nettype none
interface sit_cmd_if;
	logic valid;
	logic ready;
	logic [2:0] kind;
	logic [63:0] body_id;
	logic [63:0] zone_id;
	logic [63:0] org_id;
	logic [31:0] pop_count;
	logic [63:0] needs_ref;
	logic [63:0] target_id;
	logic [63:0] value;
	modport source (output valid, kind, body_id, zone_id, org_id, pop_count, needs_ref,
		target_id, value, input ready);
	modport sink (input valid, kind, body_id, zone_id, org_id, pop_count, needs_ref,
		target_id, value, output ready);
endinterface

interface sit_res_if;
	logic valid;
	logic ready;
	logic [1:0] status;
	logic [63:0] entry_id_out;
	logic [5:0] slot;
	logic [31:0] count_out;
	logic [63:0] ref_out;
	logic [63:0] due_out;
	logic [63:0] prov_out;
	modport source (output valid, status, entry_id_out, slot, count_out, ref_out, due_out,
		prov_out, input ready);
	modport sink (input valid, status, entry_id_out, slot, count_out, ref_out, due_out,
		prov_out, output ready);
endinterface

interface sit_cfg_if;
	logic valid;
	logic ready;
	logic [6:0] data;
	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

### rtl/sit_mem.sv
`default_nettype none
module sit_mem #(
	parameter int Depth = sit_pkg::MaxEntriesDefault,
	localparam int AW = (Depth > 1) ? $clog2(Depth) : 1
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [AW-1:0] waddr,
	input wire sit_pkg::entry_t wdata,
	input wire logic [AW-1:0] raddr,
	output sit_pkg::entry_t rdata
);
	sit_pkg::entry_t mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

### rtl/sorted_id_table_engine_unit.sv
// Channel | Dir | Payload
// cmd     | in  | kind, body_id, zone_id, org_id, pop_count, needs_ref, target_id, value
// res     | out | status, entry_id_out, slot, count_out, ref_out, due_out, prov_out
// cfg     | in  | data: capacity_in_use
// One item at a time. The key hash mixes body_id at the accept, then zone_id (S_H2)
// and org_id (S_H3); the linear search reads each slot (S_SRD), then compares it (S_SCHK);
// insert shifts entries up, reading (S_MRD) then writing (S_MWR) each moved entry.
// Reset clears control state and the fill count and sets the capacity to 64; memory content is not cleared.
// The next item is taken once the result register has been loaded and handed off.
`default_nettype none
module sorted_id_table_engine_unit #(
	parameter int MaxEntries = sit_pkg::MaxEntriesDefault
) (
	input wire logic clk,
	input wire logic arst_n,
	sit_cmd_if.sink cmd,
	sit_res_if.source res,
	sit_cfg_if.sink cfg
);
	localparam int AW = (MaxEntries > 1) ? $clog2(MaxEntries) : 1;
	localparam int CW = $clog2(MaxEntries + 1);

	sit_pkg::state_t state_q, state_d;
	logic [6:0] cap_q;
	logic [CW-1:0] used_q, used_d, idx_q, idx_d;
	logic [CW-1:0] pos_q, pos_d;
	logic [2:0] kind_q;
	logic [63:0] k0_q, k1_q, k2_q, rf_q, val_q, h_q, h_d;
	logic [31:0] cnt_q;
	logic [1:0] st_q, st_d;
	logic res_valid_q;
	sit_pkg::result_t res_q, res_d;
	logic res_load;
	logic mwe;
	logic [AW-1:0] mwaddr, mraddr;
	sit_pkg::entry_t mwdata, mrdata, newent;
	logic [CW-1:0] lim;

	sit_mem #(.Depth(MaxEntries)) u_mem (
		.clk(clk), .we(mwe), .waddr(mwaddr), .wdata(mwdata), .raddr(mraddr), .rdata(mrdata)
	);

	assign lim = ({25'd0, cap_q} < 32'(MaxEntries)) ? CW'(cap_q) : CW'(MaxEntries);
	assign cmd.ready = (state_q == sit_pkg::S_IDLE) && !res_valid_q;
	assign cfg.ready = 1'b1;
	assign res.valid = res_valid_q;
	assign res.status = res_q.status;
	assign res.entry_id_out = res_q.entry_id_out;
	assign res.slot = res_q.slot;
	assign res.count_out = res_q.count_out;
	assign res.ref_out = res_q.ref_out;
	assign res.due_out = res_q.due_out;
	assign res.prov_out = res_q.prov_out;

	always_comb begin
		newent.id = h_q;
		newent.k0 = k0_q;
		newent.k1 = k1_q;
		newent.k2 = k2_q;
		newent.cnt = cnt_q;
		newent.rf = rf_q;
		newent.due = '1;
		newent.prov = sit_pkg::mix(h_q, {32'd0, cnt_q});
	end

	always_comb begin
		state_d = state_q;
		used_d = used_q;
		idx_d = idx_q;
		pos_d = pos_q;
		h_d = h_q;
		st_d = st_q;
		res_d = res_q;
		res_load = 1'b0;
		mwe = 1'b0;
		mwaddr = idx_q[AW-1:0];
		mwdata = mrdata;
		mraddr = idx_q[AW-1:0];
		unique case (state_q)
			sit_pkg::S_IDLE: begin
				if (cmd.valid && cmd.ready) begin
					h_d = (cmd.kind == sit_pkg::K_REG || cmd.kind == sit_pkg::K_LKKEY) ?
						sit_pkg::mix(sit_pkg::IdSeed, cmd.body_id) : cmd.target_id;
					idx_d = '0;
					if (cmd.kind == sit_pkg::K_REG || cmd.kind == sit_pkg::K_LKKEY) begin
						state_d = sit_pkg::S_H2;
					end else if (cmd.kind == sit_pkg::K_CLR || cmd.kind == sit_pkg::K_NONE) begin
						if (cmd.kind == sit_pkg::K_CLR) begin
							used_d = '0;
						end
						res_d = '0;
						res_load = 1'b1;
					end else begin
						state_d = sit_pkg::S_SRD;
					end
				end
			end
			sit_pkg::S_H1: state_d = sit_pkg::S_H2;
			sit_pkg::S_H2: begin
				h_d = sit_pkg::mix(h_q, k1_q);
				state_d = sit_pkg::S_H3;
			end
			sit_pkg::S_H3: begin
				h_d = sit_pkg::mix(h_q, k2_q);
				if (h_d == 64'd0) begin
					h_d = 64'd1;
				end
				state_d = (kind_q == sit_pkg::K_REG && used_q >= lim) ?
					sit_pkg::S_OUT : sit_pkg::S_SRD;
				st_d = sit_pkg::ST_FULL;
			end
			sit_pkg::S_SRD: begin
				if (idx_q >= used_q) begin
					st_d = (kind_q == sit_pkg::K_REG) ? sit_pkg::ST_OK : sit_pkg::ST_NF;
					state_d = (kind_q == sit_pkg::K_REG) ? sit_pkg::S_MRD : sit_pkg::S_OUT;
					pos_d = idx_q;
					idx_d = used_q;
				end else begin
					state_d = sit_pkg::S_SCHK;
				end
			end
			sit_pkg::S_SCHK: begin
				if (mrdata.id == h_q) begin
					st_d = (kind_q == sit_pkg::K_REG) ? sit_pkg::ST_DUP : sit_pkg::ST_OK;
					state_d = (kind_q == sit_pkg::K_REG || kind_q == sit_pkg::K_LKID ||
						kind_q == sit_pkg::K_LKKEY) ? sit_pkg::S_EOUT : sit_pkg::S_UPD;
				end else if (mrdata.id > h_q) begin
					st_d = (kind_q == sit_pkg::K_REG) ? sit_pkg::ST_OK : sit_pkg::ST_NF;
					state_d = (kind_q == sit_pkg::K_REG) ? sit_pkg::S_MRD : sit_pkg::S_OUT;
					pos_d = idx_q;
					idx_d = used_q;
					h_d = h_q;
				end else begin
					idx_d = idx_q + 1'b1;
					state_d = sit_pkg::S_SRD;
				end
			end
			sit_pkg::S_MRD: begin
				if (idx_q == pos_q) begin
					state_d = sit_pkg::S_INS;
				end else begin
					mraddr = AW'(idx_q - 1'b1);
					state_d = sit_pkg::S_MWR;
				end
			end
			sit_pkg::S_MWR: begin
				mwe = 1'b1;
				mwdata = mrdata;
				idx_d = idx_q - 1'b1;
				state_d = sit_pkg::S_MRD;
			end
			sit_pkg::S_INS: begin
				mwe = 1'b1;
				mwdata = newent;
				used_d = used_q + 1'b1;
				res_d.status = sit_pkg::ST_OK;
				res_d.entry_id_out = h_q;
				res_d.slot = 6'(idx_q);
				res_d.count_out = newent.cnt;
				res_d.ref_out = newent.rf;
				res_d.due_out = newent.due;
				res_d.prov_out = newent.prov;
				res_load = 1'b1;
				state_d = sit_pkg::S_IDLE;
			end
			sit_pkg::S_UPD: begin
				mwe = 1'b1;
				mwdata = mrdata;
				if (kind_q == sit_pkg::K_SDUE) begin
					mwdata.due = val_q;
				end else if (kind_q == sit_pkg::K_SPROV) begin
					mwdata.prov = val_q;
				end else begin
					mwdata.prov = sit_pkg::mix(mrdata.prov, val_q);
				end
				res_d.status = sit_pkg::ST_OK;
				res_d.entry_id_out = h_q;
				res_d.slot = 6'(idx_q);
				res_d.count_out = mwdata.cnt;
				res_d.ref_out = mwdata.rf;
				res_d.due_out = mwdata.due;
				res_d.prov_out = mwdata.prov;
				res_load = 1'b1;
				state_d = sit_pkg::S_IDLE;
			end
			sit_pkg::S_ERD: state_d = sit_pkg::S_EOUT;
			sit_pkg::S_EOUT: begin
				res_d.status = st_q;
				res_d.entry_id_out = h_q;
				res_d.slot = 6'(idx_q);
				res_d.count_out = mrdata.cnt;
				res_d.ref_out = mrdata.rf;
				res_d.due_out = mrdata.due;
				res_d.prov_out = mrdata.prov;
				res_load = 1'b1;
				state_d = sit_pkg::S_IDLE;
			end
			sit_pkg::S_OUT: begin
				res_d = '0;
				res_d.status = st_q;
				res_d.entry_id_out = h_q;
				res_load = 1'b1;
				state_d = sit_pkg::S_IDLE;
			end
			default: state_d = sit_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sit_pkg::S_IDLE;
			used_q <= '0;
			cap_q <= sit_pkg::CapReset;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			used_q <= used_d;
			if (cfg.valid) begin
				cap_q <= cfg.data;
			end
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_q <= idx_d;
		pos_q <= pos_d;
		h_q <= h_d;
		st_q <= st_d;
		if (res_load) begin
			res_q <= res_d;
		end
		if (cmd.valid && cmd.ready) begin
			kind_q <= cmd.kind;
			k0_q <= cmd.body_id;
			k1_q <= cmd.zone_id;
			k2_q <= cmd.org_id;
			cnt_q <= cmd.pop_count;
			rf_q <= cmd.needs_ref;
			val_q <= cmd.value;
		end
	end

`ifndef NO_ASSERTIONS
	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= CW'(MaxEntries)) else $error("fill count beyond depth");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != sit_pkg::S_IDLE) |-> !cmd.ready) else $error("accept while busy");
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && !res.ready) |=> res_valid_q) else $error("result dropped");
	a_ins_grow: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sit_pkg::S_INS) |=> (used_q == $past(used_q) + 1'b1))
		else $error("insert did not grow table");
`endif
endmodule
`default_nettype wire
